/* rtl/smfp_pkg.sv */
package smfp_pkg;

  localparam int DataW  = 8;
  localparam int TickW  = 40;
  localparam int QtyW   = 28;
  localparam int TempoW = 24;

  // result queue between parser and output port
  localparam int ResDepth = 4;
  localparam int ResPtrW  = 2;
  localparam int ResCntW  = 3;

  // stream packing of one result on tdata
  localparam int OutDataW = 80;

  localparam logic [TickW-1:0] TICK_MAX = {TickW{1'b1}};

  // status and meta codes
  localparam logic [7:0] ST_DATA_MAX = 8'h7F;
  localparam logic [7:0] ST_FIRST    = 8'h80;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_ESCAPE   = 8'hF7;
  localparam logic [7:0] ST_REALTIME = 8'hF8;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] ST_SONG_POS = 8'hF2;
  localparam logic [7:0] ST_MTC_QF   = 8'hF1;
  localparam logic [7:0] ST_SONG_SEL = 8'hF3;
  localparam logic [2:0] VLQ_MAX_BYTES = 3'd4;
  localparam logic [QtyW-1:0] TEMPO_META_LEN = 28'd3;

  typedef enum logic [1:0] {
    KIND_WIRE  = 2'd0,
    KIND_TEMPO = 2'd1,
    KIND_ERR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [DataW-1:0]   wire_byte;
    logic [TickW-1:0]   event_tick;
    logic [TempoW-1:0]  tempo_value;
    logic               message_end;
    logic               last_result;
  } res_t;

  // up to two results per request, second only when first is present
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } parse_out_t;

  // total message length including status, 1 to 3
  function automatic logic [1:0] msg_len(input logic [7:0] s);
    logic [1:0] n;
    n = 2'd1;
    if (s < ST_SYSEX) begin
      if (s >= 8'hC0 && s < 8'hE0) n = 2'd2;
      else n = 2'd3;
    end else if (s == ST_MTC_QF || s == ST_SONG_SEL) begin
      n = 2'd2;
    end else if (s == ST_SONG_POS) begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

/* rtl/smf_track_to_wire_parser_unit.sv */
// path: a request reaches the input register on acceptance, is parsed and queued when
// the 4-entry result queue has room for two results, and its results then drive out_tvalid
// throughput: one byte per cycle while the result queue has room for two results; a
// running-status byte makes two results, both leaving via the single result port
// reset: rst_n synchronous active low clears parse state, tick, running status,
// error flag, input register and result queue
module smf_track_to_wire_parser_unit
  import smfp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] data_byte
  input  logic                in_tuser,   // [0] first_of_track
  input  logic                in_tlast,   // last_of_track
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [7:0] wire_byte, [47:8] event_tick,
                                          // [71:48] tempo_value, [72] last_result
  output logic [1:0]          out_tuser,  // [1:0] kind
  output logic                out_tlast   // message_end
);

  logic               in_vld_r;
  logic [DataW-1:0]   in_data_r;
  logic               in_first_r, in_last_r;
  logic               fire, pop;
  parse_out_t         pres;

  res_t               q_r [ResDepth];
  logic [ResPtrW-1:0] wr_r, rd_r, wr1;
  logic [ResCntW-1:0] cnt_r, cnt_nxt, push_n;
  res_t               head;

  // parse when the queue has room for two results
  assign fire      = in_vld_r && (cnt_r <= ResCntW'(ResDepth - 2));
  assign in_tready = !in_vld_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r  <= in_tdata;
      in_first_r <= in_tuser;
      in_last_r  <= in_tlast;
    end
  end

  smfp_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .data_byte      (in_data_r),
    .first_of_track (in_first_r),
    .last_of_track  (in_last_r),
    .res            (pres)
  );

  // result queue
  assign pop    = out_tvalid && out_tready;
  assign wr1    = wr_r + ResPtrW'(1);
  assign push_n = fire ? (ResCntW'(pres.v0) + ResCntW'(pres.v1)) : '0;
  assign cnt_nxt = cnt_r + push_n - ResCntW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + push_n[ResPtrW-1:0];
      rd_r  <= rd_r + ResPtrW'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pres.v0) q_r[wr_r] <= pres.r0;
    if (fire && pres.v1) q_r[wr1]  <= pres.r1;
  end

  // output packing
  assign head       = q_r[rd_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {7'b0, head.last_result, head.tempo_value, head.event_tick,
                       head.wire_byte};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.message_end;

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ResCntW'(ResDepth))
    else $error("result queue overflow");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && pres.v0 |=> out_tvalid)
    else $error("queued result not presented");

  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> in_vld_r)
    else $error("accepted request lost");
`endif

endmodule

/* rtl/smfp_parse.sv */
module smfp_parse
  import smfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [DataW-1:0] data_byte,
  input  logic             first_of_track,
  input  logic             last_of_track,
  output parse_out_t       res
);

  typedef enum logic [8:0] {
    PH_DELTA      = 9'b000000001,
    PH_STATUS     = 9'b000000010,
    PH_META_TYPE  = 9'b000000100,
    PH_META_LEN   = 9'b000001000,
    PH_META_BODY  = 9'b000010000,
    PH_SYSEX_LEN  = 9'b000100000,
    PH_SYSEX_BODY = 9'b001000000,
    PH_DATA       = 9'b010000000,
    PH_DONE       = 9'b100000000
  } phase_t;

  phase_t             phase_r, phase_nxt, phase_e;
  logic [TickW-1:0]   tick_r, tick_nxt, tick_e;
  logic [QtyW-1:0]    qacc_r, qacc_nxt, qacc_e;
  logic [2:0]         qcnt_r, qcnt_nxt, qcnt_e;
  logic [7:0]         rs_r, rs_nxt, rs_e;
  logic [7:0]         cur_r, cur_nxt, cur_e;
  logic [QtyW-1:0]    rem_r, rem_nxt, rem_e;
  logic [7:0]         meta_r, meta_nxt, meta_e;
  logic [TempoW-1:0]  tempo_r, tempo_nxt, tempo_e;
  logic               err_r, err_nxt, err_e;

  logic [QtyW-1:0]    q_base, q_acc, rem_dec;
  logic [2:0]         q_cnt1, q_cnt_upd;
  logic               q_done, q_bad, bad, tempo_hit;
  logic [TickW:0]     tick_sum;
  logic [1:0]         n_len;
  parse_out_t         o;

  function automatic res_t mk_res(input kind_t k, input logic [7:0] wb,
                                  input logic [TempoW-1:0] tv, input logic me);
    res_t r;
    r = '0;
    r.kind        = k;
    r.wire_byte   = wb;
    r.tempo_value = tv;
    r.message_end = me;
    return r;
  endfunction

  // a new track starts from the reset state
  always_comb begin
    phase_e = first_of_track ? PH_DELTA : phase_r;
    tick_e  = first_of_track ? '0 : tick_r;
    qacc_e  = first_of_track ? '0 : qacc_r;
    qcnt_e  = first_of_track ? '0 : qcnt_r;
    rs_e    = first_of_track ? '0 : rs_r;
    cur_e   = first_of_track ? '0 : cur_r;
    rem_e   = first_of_track ? '0 : rem_r;
    meta_e  = first_of_track ? '0 : meta_r;
    tempo_e = first_of_track ? '0 : tempo_r;
    err_e   = first_of_track ? 1'b0 : err_r;
  end

  // variable-length quantity step and tick accumulation
  always_comb begin
    q_base    = (qcnt_e == 3'd0) ? '0 : qacc_e;
    q_acc     = {q_base[QtyW-8:0], data_byte[6:0]};
    q_cnt1    = qcnt_e + 3'd1;
    q_done    = !data_byte[7];
    q_bad     = data_byte[7] && (q_cnt1 >= VLQ_MAX_BYTES);
    q_cnt_upd = (q_done || q_bad) ? 3'd0 : q_cnt1;
    tick_sum  = {1'b0, tick_e} + {{(TickW+1-QtyW){1'b0}}, q_acc};
    rem_dec   = rem_e - {{(QtyW-1){1'b0}}, 1'b1};
    tempo_hit = (meta_e == META_TEMPO) && (qacc_e == TEMPO_META_LEN);
  end

  // parse one byte
  always_comb begin
    phase_nxt = phase_e;
    tick_nxt  = tick_e;
    qacc_nxt  = qacc_e;
    qcnt_nxt  = qcnt_e;
    rs_nxt    = rs_e;
    cur_nxt   = cur_e;
    rem_nxt   = rem_e;
    meta_nxt  = meta_e;
    tempo_nxt = tempo_e;
    err_nxt   = err_e;
    bad       = 1'b0;
    n_len     = 2'd1;
    o         = '0;

    if (!err_e && phase_e != PH_DONE) begin
      case (phase_e)
        PH_DELTA: begin
          qacc_nxt = q_acc;
          qcnt_nxt = q_cnt_upd;
          if (q_bad) begin
            bad = 1'b1;
          end else if (q_done) begin
            tick_nxt  = tick_sum[TickW] ? TICK_MAX : tick_sum[TickW-1:0];
            phase_nxt = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (data_byte <= ST_DATA_MAX) begin
            // running status: resend the status byte first
            if (rs_e == 8'h00) begin
              bad = 1'b1;
            end else begin
              cur_nxt = rs_e;
              n_len   = msg_len(rs_e);
              o.v0    = 1'b1;
              o.r0    = mk_res(KIND_WIRE, rs_e, '0, 1'b0);
              o.v1    = 1'b1;
              o.r1    = mk_res(KIND_WIRE, data_byte, '0, n_len <= 2'd2);
              if (n_len <= 2'd2) begin
                phase_nxt = PH_DELTA;
              end else begin
                rem_nxt   = QtyW'(n_len - 2'd2);
                phase_nxt = PH_DATA;
              end
            end
          end else begin
            if (data_byte < ST_SYSEX) rs_nxt = data_byte;
            else if (data_byte < ST_REALTIME) rs_nxt = 8'h00;
            cur_nxt = data_byte;
            n_len   = msg_len(data_byte);
            if (data_byte == ST_META) begin
              phase_nxt = PH_META_TYPE;
            end else if (data_byte == ST_SYSEX || data_byte == ST_ESCAPE) begin
              phase_nxt = PH_SYSEX_LEN;
            end else begin
              o.v0 = 1'b1;
              o.r0 = mk_res(KIND_WIRE, data_byte, '0, n_len == 2'd1);
              if (n_len == 2'd1) begin
                phase_nxt = PH_DELTA;
              end else begin
                rem_nxt   = QtyW'(n_len - 2'd1);
                phase_nxt = PH_DATA;
              end
            end
          end
        end
        PH_DATA, PH_SYSEX_BODY: begin
          rem_nxt = rem_dec;
          o.v0    = 1'b1;
          o.r0    = mk_res(KIND_WIRE, data_byte, '0, rem_dec == '0);
          if (rem_dec == '0) phase_nxt = PH_DELTA;
        end
        PH_META_TYPE: begin
          meta_nxt  = data_byte;
          phase_nxt = PH_META_LEN;
        end
        PH_META_LEN: begin
          qacc_nxt = q_acc;
          qcnt_nxt = q_cnt_upd;
          if (q_bad) begin
            bad = 1'b1;
          end else if (q_done) begin
            rem_nxt   = q_acc;
            tempo_nxt = '0;
            phase_nxt = (q_acc == '0) ? PH_DELTA : PH_META_BODY;
          end
        end
        PH_META_BODY: begin
          if (tempo_hit) tempo_nxt = {tempo_e[TempoW-9:0], data_byte};
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            if (tempo_hit) begin
              o.v0 = 1'b1;
              o.r0 = mk_res(KIND_TEMPO, 8'h00, {tempo_e[TempoW-9:0], data_byte}, 1'b0);
            end
            phase_nxt = PH_DELTA;
          end
        end
        PH_SYSEX_LEN: begin
          qacc_nxt = q_acc;
          qcnt_nxt = q_cnt_upd;
          if (q_bad) begin
            bad = 1'b1;
          end else if (q_done) begin
            rem_nxt = q_acc;
            if (cur_e == ST_SYSEX) begin
              o.v0 = 1'b1;
              o.r0 = mk_res(KIND_WIRE, ST_SYSEX, '0, q_acc == '0);
            end
            phase_nxt = (q_acc == '0) ? PH_DELTA : PH_SYSEX_BODY;
          end
        end
        default: begin
          phase_nxt = phase_e;
        end
      endcase

      // track end inside an event is malformed too
      if (!bad && last_of_track && !(phase_nxt == PH_DELTA && qcnt_nxt == 3'd0))
        bad = 1'b1;

      if (bad) begin
        o      = '0;
        o.v0   = 1'b1;
        o.r0   = mk_res(KIND_ERR, 8'h00, '0, 1'b0);
        err_nxt = 1'b1;
      end else if (last_of_track) begin
        phase_nxt = PH_DONE;
      end
    end

    // stamp tick and mark final result
    o.r0.event_tick = tick_nxt;
    o.r1.event_tick = tick_nxt;
    if (o.v1) o.r1.last_result = 1'b1;
    else if (o.v0) o.r0.last_result = 1'b1;
  end

  assign res = o;

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      tick_r  <= '0;
      qacc_r  <= '0;
      qcnt_r  <= '0;
      rs_r    <= '0;
      cur_r   <= '0;
      rem_r   <= '0;
      meta_r  <= '0;
      tempo_r <= '0;
      err_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      qacc_r  <= qacc_nxt;
      qcnt_r  <= qcnt_nxt;
      rs_r    <= rs_nxt;
      cur_r   <= cur_nxt;
      rem_r   <= rem_nxt;
      meta_r  <= meta_nxt;
      tempo_r <= tempo_nxt;
      err_r   <= err_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.v1 |-> res.v0 && res.r0.kind == KIND_WIRE && res.r1.kind == KIND_WIRE)
    else $error("second result without a wire-byte first result");

  a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.v0 && res.r0.kind == KIND_ERR |-> !res.v1 && res.r0.last_result)
    else $error("error result not alone");

  a_error_silences: assert property (@(posedge clk) disable iff (!rst_n)
    fire && err_r && !first_of_track |-> !res.v0)
    else $error("result after malformed track");
`endif

endmodule
